// ===== hw/rtl/fixed_timestep_accumulator_defines.svh =====
// assertion macros for the fixed timestep accumulator checker
// no dependencies; included by the checker file only
`ifndef FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FTA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("fta same-cycle check failed");

// next-cycle implication, disabled during reset
`define FTA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("fta next-cycle check failed");

`endif

// ===== hw/rtl/fta_pkg.sv =====
// shared widths, codes and types for the fixed timestep accumulator
// no dependencies; used by the top level and the checker
package fta_pkg;

  // default length of one step in tick-nanosecond units
  localparam int unsigned UNITS_PER_SECOND_DEF = 1000000000;

  // field widths
  localparam int unsigned TICK_W      = 30;
  localparam int unsigned CAP_W       = 10;
  localparam int unsigned ELAPSED_W   = 40;
  localparam int unsigned DROP_W      = 35;
  localparam int unsigned ALPHA_W     = 32;
  localparam int unsigned TOTAL_W     = 64;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned CFG_INDEX_W = 2;

  // register reset values
  localparam logic [TICK_W-1:0]    STEP_RATE_RST   = TICK_W'(60);
  localparam logic [CAP_W-1:0]     MAX_STEPS_RST   = CAP_W'(8);
  localparam logic [ELAPSED_W-1:0] MAX_ELAPSED_RST = ELAPSED_W'(250000000);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_RATE   = 2'd0,
    REG_MAX_STEPS   = 2'd1,
    REG_MAX_ELAPSED = 2'd2
  } cfg_reg_t;

  // input word action codes
  typedef enum logic {
    ACT_ADVANCE = 1'b0,
    ACT_CLEAR   = 1'b1
  } action_t;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PREP   = 8'b0000_0010,
    ST_MUL    = 8'b0000_0100,
    ST_ADD    = 8'b0000_1000,
    ST_DIV    = 8'b0001_0000,
    ST_FINISH = 8'b0010_0000,
    ST_ALPHA  = 8'b0100_0000,
    ST_WRITE  = 8'b1000_0000
  } state_t;

endpackage

// ===== hw/rtl/fixed_timestep_accumulator.sv =====
// fixed timestep accumulator: clamp, serial multiply, serial divide by one step
// depends on fta_pkg
//
// One word is worked on at a time. An advance word passes through a prepare
// state, the multiply at two rate bits per cycle, a saturating add, the divide
// at two quotient bits per cycle over the 64-bit sum, a state for the step cap
// and running total, the 32-bit alpha fraction and a write state, which waits
// while the output is stalled. A clear word goes straight to the write state.
// The radix-4 restoring divider is shared by the step count and the alpha
// fraction. A finished result sits in the output register while the next word
// is accepted. No clearing pass follows reset.
module fixed_timestep_accumulator #(
  parameter int unsigned UNITS_PER_SECOND = fta_pkg::UNITS_PER_SECOND_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration port
  input  logic                           cfg_we,
  input  logic [fta_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fta_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [fta_pkg::ELAPSED_W-1:0]  elapsed_ns,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fta_pkg::CAP_W-1:0]      grant_count,
  output logic [fta_pkg::DROP_W-1:0]     dropped_steps,
  output logic                           was_clamped,
  output logic [fta_pkg::ALPHA_W-1:0]    alpha_fraction,
  output logic [fta_pkg::TOTAL_W-1:0]    total_steps
);

  localparam int unsigned RW          = $clog2(UNITS_PER_SECOND);
  localparam int unsigned EW          = fta_pkg::ELAPSED_W;
  localparam int unsigned TW          = fta_pkg::TICK_W;
  localparam int unsigned SW          = fta_pkg::TOTAL_W;
  localparam int unsigned PROD_W      = EW + TW;
  localparam int unsigned MUL_STEPS   = TW / 2;
  localparam int unsigned DIV_STEPS   = SW / 2;
  localparam int unsigned ALPHA_STEPS = fta_pkg::ALPHA_W / 2;
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS);
  localparam logic [RW:0] UNIT        = (RW+1)'(UNITS_PER_SECOND);

  // configuration registers
  logic [TW-1:0]                 step_rate;
  logic [fta_pkg::CAP_W-1:0]     max_steps;
  logic [EW-1:0]                 max_elapsed;

  // accumulator state
  logic [RW-1:0]                 rem;
  logic [SW-1:0]                 step_total;

  // sequencer and datapath registers
  fta_pkg::state_t               state;
  logic [CNT_W-1:0]              cnt;
  logic [EW-1:0]                 e;
  logic [EW+1:0]                 e3;
  logic [TW-1:0]                 t;
  logic [PROD_W-1:0]             m;
  logic [SW-1:0]                 shreg;
  logic [RW-1:0]                 r;
  logic                          clamped;
  logic [fta_pkg::CAP_W-1:0]     st_steps;
  logic [fta_pkg::DROP_W-1:0]    st_dropped;

  // combinational helpers
  logic [EW+1:0]                 addend;
  logic [EW+1:0]                 psum;
  logic [PROD_W-1:0]             m_next;
  logic [SW-1:0]                 prod_sat;
  logic [SW:0]                   acc_sum;
  logic [RW:0]                   t1, t2;
  logic                          q1, q2;
  logic [RW-1:0]                 r1, r2;
  logic                          over;
  logic [fta_pkg::CAP_W-1:0]     steps_now;
  logic [SW:0]                   total_sum;
  logic                          in_take;
  logic                          out_free;

  assign in_stall = (state != fta_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate   <= fta_pkg::STEP_RATE_RST;
      max_steps   <= fta_pkg::MAX_STEPS_RST;
      max_elapsed <= fta_pkg::MAX_ELAPSED_RST;
    end else if (cfg_we) begin
      unique case (fta_pkg::cfg_reg_t'(cfg_index))
        fta_pkg::REG_STEP_RATE:   step_rate   <= cfg_data[TW-1:0];
        fta_pkg::REG_MAX_STEPS:   max_steps   <= cfg_data[fta_pkg::CAP_W-1:0];
        fta_pkg::REG_MAX_ELAPSED: max_elapsed <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  // multiplier digit: two rate bits per cycle, partial product shifts right
  always_comb begin
    case (t[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, e};
      2'd2:    addend = {1'b0, e, 1'b0};
      default: addend = e3;
    endcase
    psum   = (EW+2)'(m[PROD_W-1:TW]) + addend;
    m_next = {psum, m[TW-1:2]};
  end

  // product saturation and sum with the remainder
  always_comb begin
    prod_sat = (|m[PROD_W-1:SW]) ? '1 : m[SW-1:0];
    acc_sum  = {1'b0, prod_sat} + (SW+1)'(rem);
  end

  // radix-4 restoring divider by one step length
  always_comb begin
    t1 = {r, shreg[SW-1]};
    q1 = (t1 >= UNIT);
    r1 = q1 ? RW'(t1 - UNIT) : t1[RW-1:0];
    t2 = {r1, shreg[SW-2]};
    q2 = (t2 >= UNIT);
    r2 = q2 ? RW'(t2 - UNIT) : t2[RW-1:0];
  end

  // step cap, dropped count and running total from the quotient
  always_comb begin
    over      = (shreg > SW'(max_steps));
    steps_now = over ? max_steps : shreg[fta_pkg::CAP_W-1:0];
    total_sum = {1'b0, step_total} + (SW+1)'(steps_now);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fta_pkg::ST_IDLE;
      rem        <= '0;
      step_total <= '0;
      cnt        <= '0;
    end else begin
      unique case (state)
        fta_pkg::ST_IDLE: begin
          if (in_take) begin
            if (fta_pkg::action_t'(action) == fta_pkg::ACT_CLEAR) begin
              rem        <= '0;
              step_total <= '0;
              state      <= fta_pkg::ST_WRITE;
            end else begin
              state <= fta_pkg::ST_PREP;
            end
          end
        end
        fta_pkg::ST_PREP: begin
          cnt   <= CNT_W'(MUL_STEPS - 1);
          state <= fta_pkg::ST_MUL;
        end
        fta_pkg::ST_MUL: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= fta_pkg::ST_ADD;
          end
        end
        fta_pkg::ST_ADD: begin
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= fta_pkg::ST_DIV;
        end
        fta_pkg::ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= fta_pkg::ST_FINISH;
          end
        end
        fta_pkg::ST_FINISH: begin
          rem        <= r;
          step_total <= total_sum[SW] ? '1 : total_sum[SW-1:0];
          cnt        <= CNT_W'(ALPHA_STEPS - 1);
          state      <= fta_pkg::ST_ALPHA;
        end
        fta_pkg::ST_ALPHA: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= fta_pkg::ST_WRITE;
          end
        end
        fta_pkg::ST_WRITE: begin
          if (out_free) begin
            state <= fta_pkg::ST_IDLE;
          end
        end
        default: state <= fta_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state) inside
      fta_pkg::ST_IDLE: begin
        if (in_take) begin
          clamped    <= (elapsed_ns > max_elapsed) &&
                        (fta_pkg::action_t'(action) == fta_pkg::ACT_ADVANCE);
          e          <= (elapsed_ns > max_elapsed) ? max_elapsed : elapsed_ns;
          t          <= step_rate;
          shreg      <= '0;
          st_steps   <= '0;
          st_dropped <= '0;
        end
      end
      fta_pkg::ST_PREP: begin
        e3 <= {2'b00, e} + {1'b0, e, 1'b0};
        m  <= '0;
      end
      fta_pkg::ST_MUL: begin
        m <= m_next;
        t <= t >> 2;
      end
      fta_pkg::ST_ADD: begin
        shreg <= acc_sum[SW] ? '1 : acc_sum[SW-1:0];
        r     <= '0;
      end
      fta_pkg::ST_DIV, fta_pkg::ST_ALPHA: begin
        shreg <= {shreg[SW-3:0], q1, q2};
        r     <= r2;
      end
      fta_pkg::ST_FINISH: begin
        st_steps   <= steps_now;
        st_dropped <= over ? fta_pkg::DROP_W'(shreg - SW'(max_steps)) : '0;
        shreg      <= '0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == fta_pkg::ST_WRITE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == fta_pkg::ST_WRITE) && out_free) begin
      grant_count    <= st_steps;
      dropped_steps  <= st_dropped;
      was_clamped    <= clamped;
      alpha_fraction <= shreg[fta_pkg::ALPHA_W-1:0];
      total_steps    <= step_total;
    end
  end

endmodule

// ===== hw/rtl/fta_checker.sv =====
// port-level checks for the fixed timestep accumulator, bound to the top level
// depends on fta_pkg and fixed_timestep_accumulator_defines.svh
`include "fixed_timestep_accumulator_defines.svh"

module fta_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [fta_pkg::CAP_W-1:0]       grant_count,
  input logic [fta_pkg::DROP_W-1:0]      dropped_steps,
  input logic                            was_clamped,
  input logic [fta_pkg::ALPHA_W-1:0]     alpha_fraction,
  input logic [fta_pkg::TOTAL_W-1:0]     total_steps
);

  // a taken word leaves the block busy in the cycle after it is taken
  `FTA_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)

  // a stalled result word holds
  `FTA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(grant_count) && $stable(dropped_steps) && $stable(was_clamped) && $stable(alpha_fraction) && $stable(total_steps))

  // the running total never lags the steps granted
  `FTA_ASSERT_IMP(a_total_covers_steps, clk, rst, out_valid && (total_steps == '0), grant_count == '0)

  // a new result only comes out of a busy block
  `FTA_ASSERT_IMP(a_result_from_busy, clk, rst, !$past(rst) && $rose(out_valid), $past(in_stall))

  // the block goes idle only as it hands over a result
  `FTA_ASSERT_IMP(a_idle_with_result, clk, rst, !$past(rst) && $fell(in_stall), out_valid)

endmodule

bind fixed_timestep_accumulator fta_port_checks u_fta_port_checks (.*);
